// ===== hw/rtl/ncl_pkg.sv =====
`default_nettype none

package ncl_pkg;

  // Configuration port.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] REG_NUM_CLUSTERS = 3'd0;
  localparam logic [2:0] REG_POLAR_MODE   = 3'd1;
  localparam logic [2:0] REG_MASK_ENABLE  = 3'd2;
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd3;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd4;
  localparam logic [2:0] REG_RADIUS_SCALE = 3'd5;

  // Request codes.
  localparam logic [1:0] REQ_LOAD     = 2'd0;
  localparam logic [1:0] REQ_CLASSIFY = 2'd1;
  localparam logic [1:0] REQ_COUNT    = 2'd2;

  // Field widths.
  localparam int NCL_W     = 6;
  localparam int IMG_DIM_W = 13;
  localparam int SCALE_W   = 24;
  localparam int CI_W      = 5;
  localparam int CHAN_W    = 8;
  localparam int FEAT_W    = 16;
  localparam int LABEL_W   = 8;
  localparam int COUNT_W   = 24;
  localparam int ENTRY_W   = 4 * FEAT_W;
  localparam int SQD_W     = 2 * FEAT_W;
  localparam int DIST_W    = SQD_W + 2;

  // Reset values of the registers.
  localparam logic [NCL_W-1:0]     NUM_CLUSTERS_RST = 6'd1;
  localparam logic [IMG_DIM_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
  localparam logic [IMG_DIM_W-1:0] IMAGE_HEIGHT_RST = 13'd480;
  localparam logic [SCALE_W-1:0]   RADIUS_SCALE_RST = 24'd65536;

  localparam logic [LABEL_W-1:0] LABEL_MASKED = 8'd255;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = 24'hFFFFFF;
  localparam logic [FEAT_W-1:0]  FEAT_MAX     = 16'hFFFF;

  // Four features: blue, green, red, radius (element 0 is blue).
  typedef logic [3:0][FEAT_W-1:0] feat_vec_t;

  // Control that travels with each centroid through the distance pipeline.
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } dist_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ncl_isqrt.sv =====
`default_nettype none

module ncl_isqrt
  import ncl_pkg::*;
#(
  parameter int IN_W = 28
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [IN_W-1:0]   din,
  output logic                   done,
  output logic [IN_W/2-1:0]      root
);

  localparam int OUT_W = IN_W / 2;

  logic            run_r;
  logic            done_r;
  logic [IN_W-1:0] rem_r;
  logic [IN_W-1:0] res_r;
  logic [IN_W-1:0] bit_r;
  logic [IN_W-1:0] trial;

  // One result bit per cycle, two radicand bits consumed per step.
  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && bit_r[0]) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= din;
      res_r <= '0;
      bit_r <= IN_W'(1) << (IN_W - 2);
    end else if (run_r) begin
      if (rem_r >= trial) begin
        rem_r <= rem_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[OUT_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/ncl_dist.sv =====
`default_nettype none

module ncl_dist
  import ncl_pkg::*;
#(
  parameter int IDX_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire dist_ctl_t        ctl,
  input  wire logic [IDX_W-1:0] idx,
  input  wire feat_vec_t        feat,
  input  wire feat_vec_t        mean,
  output logic                  done,
  output logic [IDX_W-1:0]      best_idx
);

  dist_ctl_t               ctl1_r;
  dist_ctl_t               ctl2_r;
  logic [IDX_W-1:0]        idx1_r;
  logic [IDX_W-1:0]        idx2_r;
  logic [3:0][SQD_W-1:0]   sq1_r;
  logic [DIST_W-1:0]       sum2_r;
  logic [DIST_W-1:0]       best_dist_r;
  logic [IDX_W-1:0]        best_idx_r;
  logic                    done_r;
  logic [3:0][FEAT_W-1:0]  diff;

  always_comb begin
    for (int f = 0; f < 4; f++) begin
      diff[f] = (feat[f] > mean[f]) ? feat[f] - mean[f] : mean[f] - feat[f];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      done_r <= 1'b0;
    end else begin
      ctl1_r <= ctl;
      ctl2_r <= ctl1_r;
      done_r <= ctl2_r.vld && ctl2_r.last;
    end
  end

  always_ff @(posedge clk) begin
    for (int f = 0; f < 4; f++) begin
      sq1_r[f] <= diff[f] * diff[f];
    end
    idx1_r <= idx;
    sum2_r <= DIST_W'(sq1_r[0]) + DIST_W'(sq1_r[1]) + DIST_W'(sq1_r[2])
            + DIST_W'(sq1_r[3]);
    idx2_r <= idx1_r;
    // Strict less-than keeps the lowest index on a tie.
    if (ctl2_r.vld && (ctl2_r.first || sum2_r < best_dist_r)) begin
      best_dist_r <= sum2_r;
      best_idx_r  <= idx2_r;
    end
  end

  assign done     = done_r;
  assign best_idx = best_idx_r;

endmodule

`default_nettype wire

// ===== hw/rtl/pixel_nearest_centroid_labeler_core.sv =====
`default_nettype none

// A centroid load takes effect at its accept edge and busy never rises. A count read
// passes state S_CNT before its word is registered; a masked pixel's word is registered
// at its accept edge. A classified pixel feeds the N entries in use, one per cycle,
// through the shared distance pipeline, then updates the count; polar mode first adds
// the squares, the square root (one bit per cycle) and the scale step before the scan.
// Synchronous active-low reset clears the registers and all pixel counts.
module pixel_nearest_centroid_labeler_core
  import ncl_pkg::*;
#(
  parameter int MAX_CLUSTERS = 32,
  parameter int COORD_BITS   = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  // Command side
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            in_req_type,
  input  wire logic [CI_W-1:0]       in_cluster_index,
  input  wire logic [CHAN_W-1:0]     in_blue,
  input  wire logic [CHAN_W-1:0]     in_green,
  input  wire logic [CHAN_W-1:0]     in_red,
  input  wire logic [COORD_BITS-1:0] in_pix_x,
  input  wire logic [COORD_BITS-1:0] in_pix_y,
  input  wire logic                  in_mask_bit,
  input  wire logic [FEAT_W-1:0]     in_mean_blue,
  input  wire logic [FEAT_W-1:0]     in_mean_green,
  input  wire logic [FEAT_W-1:0]     in_mean_red,
  input  wire logic [FEAT_W-1:0]     in_mean_radius,
  // Result side
  output logic                       out_valid,
  output logic [LABEL_W-1:0]         out_label,
  output logic [CHAN_W-1:0]          out_blue,
  output logic [CHAN_W-1:0]          out_green,
  output logic [CHAN_W-1:0]          out_red,
  output logic [COUNT_W-1:0]         out_pixel_count
);

  localparam int IDX_W  = $clog2(MAX_CLUSTERS);
  // Signed width of a doubled offset from the image centre.
  localparam int DX_W   = ((COORD_BITS + 1 > IMG_DIM_W) ? COORD_BITS + 1 : IMG_DIM_W) + 1;
  localparam int MAG_W  = DX_W - 1;
  localparam int SQP_W  = 2 * MAG_W;
  localparam int SQ_W   = 2 * DX_W;
  localparam int PROD_W = DX_W + SCALE_W;

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQR   = 4'd1;
  localparam logic [3:0] S_SUM   = 4'd2;
  localparam logic [3:0] S_ROOT  = 4'd3;
  localparam logic [3:0] S_SCALE = 4'd4;
  localparam logic [3:0] S_RFEAT = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_WAIT  = 4'd7;
  localparam logic [3:0] S_FETCH = 4'd8;
  localparam logic [3:0] S_UPD   = 4'd9;
  localparam logic [3:0] S_CNT   = 4'd10;

  // ---------------------------------------------------------------------------
  // Configuration registers. Register i sits at byte address 4*i; the two low
  // address bits are ignored.
  // ---------------------------------------------------------------------------
  logic [NCL_W-1:0]     cfg_num_clusters_r;
  logic                 cfg_polar_mode_r;
  logic                 cfg_mask_enable_r;
  logic [IMG_DIM_W-1:0] cfg_image_width_r;
  logic [IMG_DIM_W-1:0] cfg_image_height_r;
  logic [SCALE_W-1:0]   cfg_radius_scale_r;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_num_clusters_r <= NUM_CLUSTERS_RST;
      cfg_polar_mode_r   <= 1'b0;
      cfg_mask_enable_r  <= 1'b0;
      cfg_image_width_r  <= IMAGE_WIDTH_RST;
      cfg_image_height_r <= IMAGE_HEIGHT_RST;
      cfg_radius_scale_r <= RADIUS_SCALE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_NUM_CLUSTERS: cfg_num_clusters_r <= pwdata[NCL_W-1:0];
        REG_POLAR_MODE:   cfg_polar_mode_r   <= pwdata[0];
        REG_MASK_ENABLE:  cfg_mask_enable_r  <= pwdata[0];
        REG_IMAGE_WIDTH:  cfg_image_width_r  <= pwdata[IMG_DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg_image_height_r <= pwdata[IMG_DIM_W-1:0];
        REG_RADIUS_SCALE: cfg_radius_scale_r <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_NUM_CLUSTERS: prdata = CFG_DATA_W'(cfg_num_clusters_r);
      REG_POLAR_MODE:   prdata = CFG_DATA_W'(cfg_polar_mode_r);
      REG_MASK_ENABLE:  prdata = CFG_DATA_W'(cfg_mask_enable_r);
      REG_IMAGE_WIDTH:  prdata = CFG_DATA_W'(cfg_image_width_r);
      REG_IMAGE_HEIGHT: prdata = CFG_DATA_W'(cfg_image_height_r);
      REG_RADIUS_SCALE: prdata = CFG_DATA_W'(cfg_radius_scale_r);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Command decode.
  // ---------------------------------------------------------------------------
  logic [3:0]       state_r;
  logic             accept;
  logic [8:0]       idx_ext;
  logic             idx_ok;
  logic [IDX_W-1:0] in_addr;
  logic [8:0]       ncl_ext;
  logic [8:0]       last_ext;
  logic [IDX_W-1:0] last_idx;

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign idx_ext = 9'(in_cluster_index);
  assign idx_ok  = idx_ext < 9'(MAX_CLUSTERS);
  assign in_addr = idx_ext[IDX_W-1:0];

  // A cluster count of zero scans one entry; any count above the table scans all.
  assign ncl_ext  = 9'(cfg_num_clusters_r);
  assign last_ext = (ncl_ext == 9'd0)                ? 9'd0 :
                    (ncl_ext > 9'(MAX_CLUSTERS))     ? 9'(MAX_CLUSTERS - 1) :
                                                       ncl_ext - 9'd1;
  assign last_idx = last_ext[IDX_W-1:0];

  // Doubled offsets from the image centre. The true value always fits in DX_W
  // signed bits, so modular subtraction gives the right two's complement word.
  logic [DX_W-1:0]  dx_w;
  logic [DX_W-1:0]  dy_w;
  logic [MAG_W-1:0] mag_x;
  logic [MAG_W-1:0] mag_y;
  logic [DX_W-1:0]  neg_dx;
  logic [DX_W-1:0]  neg_dy;

  assign dx_w   = DX_W'({in_pix_x, 1'b0}) - DX_W'(cfg_image_width_r);
  assign dy_w   = DX_W'({in_pix_y, 1'b0}) - DX_W'(cfg_image_height_r);
  assign neg_dx = -dx_w;
  assign neg_dy = -dy_w;
  assign mag_x  = dx_w[DX_W-1] ? neg_dx[MAG_W-1:0] : dx_w[MAG_W-1:0];
  assign mag_y  = dy_w[DX_W-1] ? neg_dy[MAG_W-1:0] : dy_w[MAG_W-1:0];

  // ---------------------------------------------------------------------------
  // Centroid table and pixel counts. Both have one write and one registered
  // read port. Counts carry a valid bit per entry so reset and loads clear
  // them at once; an entry without its valid bit reads as zero.
  // ---------------------------------------------------------------------------
  logic [ENTRY_W-1:0]      cent_mem [MAX_CLUSTERS];
  logic [ENTRY_W-1:0]      cent_rdata_r;
  logic [IDX_W-1:0]        cent_raddr;
  logic [COUNT_W-1:0]      cnt_mem [MAX_CLUSTERS];
  logic [COUNT_W-1:0]      cnt_rdata_r;
  logic [IDX_W-1:0]        cnt_raddr;
  logic [MAX_CLUSTERS-1:0] cnt_vld_r;
  logic [COUNT_W-1:0]      cnt_cur;
  logic [COUNT_W-1:0]      cnt_new;
  logic [IDX_W-1:0]        scan_idx_r;
  logic [IDX_W-1:0]        dist_best;
  logic                    dist_done;
  logic                    load_wr;

  assign load_wr    = accept && (in_req_type == REQ_LOAD) && idx_ok;
  assign cent_raddr = (state_r == S_SCAN) ? scan_idx_r : dist_best;
  assign cnt_raddr  = (state_r == S_IDLE) ? in_addr : dist_best;
  assign cnt_cur    = cnt_vld_r[dist_best] ? cnt_rdata_r : '0;
  assign cnt_new    = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (load_wr) begin
      cent_mem[in_addr] <= {in_mean_radius, in_mean_red, in_mean_green, in_mean_blue};
    end
    cent_rdata_r <= cent_mem[cent_raddr];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_UPD) begin
      cnt_mem[dist_best] <= cnt_new;
    end
    cnt_rdata_r <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
    end else if (load_wr) begin
      cnt_vld_r[in_addr] <= 1'b0;
    end else if (state_r == S_UPD) begin
      cnt_vld_r[dist_best] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Radius feature: squares, iterative square root, then the Q16 scale.
  // ---------------------------------------------------------------------------
  logic [MAG_W-1:0]  mag_x_r;
  logic [MAG_W-1:0]  mag_y_r;
  logic [SQP_W-1:0]  sq_x_r;
  logic [SQP_W-1:0]  sq_y_r;
  logic [SQ_W-1:0]   sq_sum;
  logic [DX_W-1:0]   root;
  logic              root_done;
  logic [PROD_W-1:0] prod_r;
  logic              prod_sat;

  assign sq_sum   = SQ_W'(sq_x_r) + SQ_W'(sq_y_r);
  assign prod_sat = |prod_r[PROD_W-1:2*FEAT_W];

  ncl_isqrt #(
    .IN_W (SQ_W)
  ) u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_SUM),
    .din   (sq_sum),
    .done  (root_done),
    .root  (root)
  );

  // ---------------------------------------------------------------------------
  // Sequencer. The scan feeds one centroid per cycle into the shared distance
  // pipeline, which keeps the running minimum.
  // ---------------------------------------------------------------------------
  feat_vec_t          feat_r;
  feat_vec_t          mean_in;
  dist_ctl_t          rd_ctl_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic [CI_W-1:0]    ci_r;
  logic               cnt_ok_r;
  logic               out_valid_r;
  logic [LABEL_W-1:0] out_label_r;
  logic [CHAN_W-1:0]  out_blue_r;
  logic [CHAN_W-1:0]  out_green_r;
  logic [CHAN_W-1:0]  out_red_r;
  logic [COUNT_W-1:0] out_count_r;

  // The radius mean only counts in polar mode; otherwise both sides are zero.
  assign mean_in[0] = cent_rdata_r[FEAT_W-1:0];
  assign mean_in[1] = cent_rdata_r[2*FEAT_W-1:FEAT_W];
  assign mean_in[2] = cent_rdata_r[3*FEAT_W-1:2*FEAT_W];
  assign mean_in[3] = cfg_polar_mode_r ? cent_rdata_r[4*FEAT_W-1:3*FEAT_W] : '0;

  ncl_dist #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (rd_ctl_r),
    .idx      (rd_idx_r),
    .feat     (feat_r),
    .mean     (mean_in),
    .done     (dist_done),
    .best_idx (dist_best)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_ctl_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_ctl_r    <= '0;
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept && in_req_type == REQ_COUNT) begin
            state_r <= S_CNT;
          end else if (accept && in_req_type == REQ_CLASSIFY) begin
            if (cfg_mask_enable_r && !in_mask_bit) begin
              out_valid_r <= 1'b1;
            end else if (cfg_polar_mode_r) begin
              state_r <= S_SQR;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SQR:   state_r <= S_SUM;
        S_SUM:   state_r <= S_ROOT;
        S_ROOT: begin
          if (root_done) begin
            state_r <= S_SCALE;
          end
        end
        S_SCALE: state_r <= S_RFEAT;
        S_RFEAT: state_r <= S_SCAN;
        S_SCAN: begin
          rd_ctl_r <= '{vld: 1'b1, first: (scan_idx_r == '0),
                        last: (scan_idx_r == last_idx)};
          if (scan_idx_r == last_idx) begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (dist_done) begin
            state_r <= S_FETCH;
          end
        end
        S_FETCH: state_r <= S_UPD;
        S_UPD: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        S_CNT: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      feat_r[0]  <= {in_blue, 8'h00};
      feat_r[1]  <= {in_green, 8'h00};
      feat_r[2]  <= {in_red, 8'h00};
      feat_r[3]  <= '0;
      mag_x_r    <= mag_x;
      mag_y_r    <= mag_y;
      ci_r       <= in_cluster_index;
      cnt_ok_r   <= idx_ok && cnt_vld_r[in_addr];
      scan_idx_r <= '0;
    end
    if (state_r == S_SQR) begin
      sq_x_r <= SQP_W'(mag_x_r) * SQP_W'(mag_x_r);
      sq_y_r <= SQP_W'(mag_y_r) * SQP_W'(mag_y_r);
    end
    if (state_r == S_SCALE) begin
      prod_r <= PROD_W'(root) * PROD_W'(cfg_radius_scale_r);
    end
    if (state_r == S_RFEAT) begin
      feat_r[3] <= prod_sat ? FEAT_MAX : prod_r[2*FEAT_W-1:FEAT_W];
    end
    if (state_r == S_SCAN) begin
      rd_idx_r <= scan_idx_r;
      if (scan_idx_r != last_idx) begin
        scan_idx_r <= scan_idx_r + IDX_W'(1);
      end
    end

    if (state_r == S_IDLE) begin
      // Masked pixel result.
      out_label_r <= LABEL_MASKED;
      out_blue_r  <= '0;
      out_green_r <= '0;
      out_red_r   <= '0;
      out_count_r <= '0;
    end else if (state_r == S_CNT) begin
      out_label_r <= LABEL_W'(ci_r);
      out_blue_r  <= '0;
      out_green_r <= '0;
      out_red_r   <= '0;
      out_count_r <= cnt_ok_r ? cnt_rdata_r : '0;
    end else if (state_r == S_UPD) begin
      out_label_r <= LABEL_W'(dist_best);
      out_blue_r  <= cent_rdata_r[FEAT_W-1:CHAN_W];
      out_green_r <= cent_rdata_r[2*FEAT_W-1:FEAT_W+CHAN_W];
      out_red_r   <= cent_rdata_r[3*FEAT_W-1:2*FEAT_W+CHAN_W];
      out_count_r <= cnt_new;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_label       = out_label_r;
  assign out_blue        = out_blue_r;
  assign out_green       = out_green_r;
  assign out_red         = out_red_r;
  assign out_pixel_count = out_count_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_busy_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted command");

  a_dist_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    dist_done |-> (state_r == S_WAIT))
    else $error("distance scan finished outside the wait state");

  a_root_done_in_root: assert property (@(posedge clk) disable iff (!rst_n)
    root_done |-> (state_r == S_ROOT))
    else $error("square root finished outside its wait state");

  a_update_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |=> (out_valid && !busy && out_pixel_count != '0))
    else $error("classified pixel did not produce a word with a nonzero count");

endmodule

`default_nettype wire

// ===== bench/pixel_nearest_centroid_labeler_core_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the nearest-centroid pixel labeler.
module pixel_nearest_centroid_labeler_core_tb;
  import ncl_pkg::*;

  localparam int COORD_W = 12;
  localparam int ENTRIES = 32;
  // Request code 3 is not defined by the block and must be ignored.
  localparam logic [1:0] REQ_RESERVED = 2'd3;
  // Settling wait, kept well above the time a polar classify over all 32 entries needs.
  localparam int SETTLE_CYCLES = 100;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 160;

  // One command word as it goes into the block. means[0] is blue.
  typedef struct packed {
    logic [1:0]         req;
    logic [CI_W-1:0]    idx;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  red;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               mask;
    feat_vec_t          means;
  } pixel_cmd_t;

  // One result word as it comes out of the block.
  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  red;
    logic [COUNT_W-1:0] count;
  } label_word_t;

  // A row of the directed list: either a register write or a command word,
  // the latter optionally with a result word written out by hand.
  typedef struct packed {
    logic                  is_reg;
    logic [2:0]            reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    pixel_cmd_t            cmd;
    logic                  typed;
    label_word_t           want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_req_type = '0;
  logic [CI_W-1:0]    in_cluster_index = '0;
  logic [CHAN_W-1:0]  in_blue = '0;
  logic [CHAN_W-1:0]  in_green = '0;
  logic [CHAN_W-1:0]  in_red = '0;
  logic [COORD_W-1:0] in_pix_x = '0;
  logic [COORD_W-1:0] in_pix_y = '0;
  logic               in_mask_bit = 1'b0;
  logic [FEAT_W-1:0]  in_mean_blue = '0;
  logic [FEAT_W-1:0]  in_mean_green = '0;
  logic [FEAT_W-1:0]  in_mean_red = '0;
  logic [FEAT_W-1:0]  in_mean_radius = '0;

  logic               out_valid;
  logic [LABEL_W-1:0] out_label;
  logic [CHAN_W-1:0]  out_blue;
  logic [CHAN_W-1:0]  out_green;
  logic [CHAN_W-1:0]  out_red;
  logic [COUNT_W-1:0] out_pixel_count;

  pixel_nearest_centroid_labeler_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_cluster_index (in_cluster_index),
    .in_blue          (in_blue),
    .in_green         (in_green),
    .in_red           (in_red),
    .in_pix_x         (in_pix_x),
    .in_pix_y         (in_pix_y),
    .in_mask_bit      (in_mask_bit),
    .in_mean_blue     (in_mean_blue),
    .in_mean_green    (in_mean_green),
    .in_mean_red      (in_mean_red),
    .in_mean_radius   (in_mean_radius),
    .out_valid        (out_valid),
    .out_label        (out_label),
    .out_blue         (out_blue),
    .out_green        (out_green),
    .out_red          (out_red),
    .out_pixel_count  (out_pixel_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the block's state and registers, kept by the predictor.
  feat_vec_t             centroid_means [ENTRIES];
  logic [COUNT_W-1:0]    pixel_counts [ENTRIES];
  logic [NCL_W-1:0]      cfg_clusters;
  logic                  cfg_polar;
  logic                  cfg_mask;
  logic [IMG_DIM_W-1:0]  cfg_width;
  logic [IMG_DIM_W-1:0]  cfg_height;
  logic [SCALE_W-1:0]    cfg_scale;

  // Result words predicted but not yet seen, oldest first.
  label_word_t pending_labels[$];
  int          err_count = 0;
  int          stall_cycles = 0;

  // Bit-by-bit integer square root, floor of the true root.
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    int b;
    root = 0;
    for (b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Distance from the image center in doubled pixel units, scaled by the Q16
  // factor and saturated to the Q8.8 feature range.
  function automatic logic [FEAT_W-1:0] radius_feature(input logic [COORD_W-1:0] x,
                                                       input logic [COORD_W-1:0] y);
    longint dx;
    longint dy;
    longint unsigned r;
    longint unsigned f;
    dx = 2 * longint'(x) - longint'(cfg_width);
    dy = 2 * longint'(y) - longint'(cfg_height);
    r = int_sqrt(dx * dx + dy * dy);
    f = (r * cfg_scale) >> 16;
    return (f > 65535) ? FEAT_MAX : f[FEAT_W-1:0];
  endfunction

  function automatic longint unsigned sq_diff(input logic [FEAT_W-1:0] a,
                                              input logic [FEAT_W-1:0] b);
    longint unsigned d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  // Applies one accepted command word to the shadow state. Returns 1 when the
  // word yields a result, which is then left in w.
  function automatic logic apply_command(input pixel_cmd_t c, output label_word_t w);
    feat_vec_t feat;
    int n;
    int nfeat;
    int best;
    int i;
    int f;
    longint unsigned d;
    longint unsigned best_d;
    w = '0;
    case (c.req)
      REQ_LOAD: begin
        centroid_means[c.idx] = c.means;
        pixel_counts[c.idx] = '0;
        return 1'b0;
      end
      REQ_COUNT: begin
        w.label = c.idx;
        w.count = pixel_counts[c.idx];
        return 1'b1;
      end
      REQ_CLASSIFY: begin
        if (cfg_mask && !c.mask) begin
          w.label = LABEL_MASKED;
          return 1'b1;
        end
        feat[0] = {c.blue, 8'h00};
        feat[1] = {c.green, 8'h00};
        feat[2] = {c.red, 8'h00};
        feat[3] = cfg_polar ? radius_feature(c.x, c.y) : '0;
        nfeat = cfg_polar ? 4 : 3;
        // Out-of-range entry counts are clamped to the table.
        n = (cfg_clusters == 0) ? 1 : (cfg_clusters > ENTRIES) ? ENTRIES : cfg_clusters;
        best = 0;
        best_d = 0;
        for (i = 0; i < n; i++) begin
          d = 0;
          for (f = 0; f < nfeat; f++) d += sq_diff(feat[f], centroid_means[i][f]);
          // Strict compare keeps the lowest index on a tie.
          if (i == 0 || d < best_d) begin
            best_d = d;
            best = i;
          end
        end
        if (pixel_counts[best] != COUNT_MAX) pixel_counts[best] = pixel_counts[best] + 1'b1;
        w.label = best;
        w.blue = centroid_means[best][0][15:8];
        w.green = centroid_means[best][1][15:8];
        w.red = centroid_means[best][2][15:8];
        w.count = pixel_counts[best];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  function automatic stim_row_t cmd_row(input logic [1:0] req, input logic [CI_W-1:0] idx,
                                        input logic [7:0] b, g, r,
                                        input logic [COORD_W-1:0] x, y,
                                        input logic m, input feat_vec_t means);
    stim_row_t row;
    row = '0;
    row.cmd.req = req;
    row.cmd.idx = idx;
    row.cmd.blue = b;
    row.cmd.green = g;
    row.cmd.red = r;
    row.cmd.x = x;
    row.cmd.y = y;
    row.cmd.mask = m;
    row.cmd.means = means;
    return row;
  endfunction

  function automatic stim_row_t with_word(input stim_row_t row, input logic [7:0] label,
                                          input logic [7:0] b, g, r,
                                          input logic [COUNT_W-1:0] count);
    row.typed = 1'b1;
    row.want = {label, b, g, r, count};
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [2:0] idx, input logic [31:0] val);
    stim_row_t row;
    row = '0;
    row.is_reg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  // Mostly uniform values, with the two extremes picked one time in eight.
  function automatic int rand_edge(input int max);
    if ($urandom_range(7) == 0) return $urandom_range(1) ? max : 0;
    return $urandom_range(max);
  endfunction

  // Random traffic is dominated by classifies against a fully loaded table,
  // with count reads and reloads mixed in, and the odd reserved request.
  function automatic pixel_cmd_t random_command();
    pixel_cmd_t c;
    int pick;
    c = '0;
    pick = $urandom_range(99);
    c.req = (pick < 70) ? REQ_CLASSIFY : (pick < 84) ? REQ_COUNT :
            (pick < 97) ? REQ_LOAD : REQ_RESERVED;
    c.idx = $urandom_range(ENTRIES - 1);
    c.blue = rand_edge(255);
    c.green = rand_edge(255);
    c.red = rand_edge(255);
    c.x = rand_edge(4095);
    c.y = rand_edge(4095);
    c.mask = $urandom_range(1);
    c.means = {$urandom, $urandom};
    return c;
  endfunction

  // Presents a command word and holds it until the block takes it. The word
  // is accepted at the first edge where busy is low. start is left high; the
  // caller lowers it only if no word follows in the same cycle.
  task automatic send_item(input pixel_cmd_t c, input logic typed, input label_word_t want);
    label_word_t w;
    start <= 1'b1;
    in_req_type <= c.req;
    in_cluster_index <= c.idx;
    in_blue <= c.blue;
    in_green <= c.green;
    in_red <= c.red;
    in_pix_x <= c.x;
    in_pix_y <= c.y;
    in_mask_bit <= c.mask;
    in_mean_blue <= c.means[0];
    in_mean_green <= c.means[1];
    in_mean_red <= c.means[2];
    in_mean_radius <= c.means[3];
    @(posedge clk);
    while (busy) @(posedge clk);
    if (apply_command(c, w)) pending_labels.push_back(typed ? want : w);
  endtask

  // Random sender gaps: each cycle is left idle with the given odds.
  task automatic idle_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Waits until every predicted word has come back, then lets the block settle
  // so that a register write cannot land on work still in flight.
  task automatic drain_and_settle();
    start <= 1'b0;
    while (pending_labels.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one register through the APB port, reads it back, and mirrors the
  // new value into the predictor.
  task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] val);
    logic [CFG_DATA_W-1:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    check_field("register readback", val, got);
    case (idx)
      REG_NUM_CLUSTERS: cfg_clusters = val[NCL_W-1:0];
      REG_POLAR_MODE:   cfg_polar = val[0];
      REG_MASK_ENABLE:  cfg_mask = val[0];
      REG_IMAGE_WIDTH:  cfg_width = val[IMG_DIM_W-1:0];
      REG_IMAGE_HEIGHT: cfg_height = val[IMG_DIM_W-1:0];
      REG_RADIUS_SCALE: cfg_scale = val[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  // Result checker. The block cannot be stalled, so every cycle with out_valid
  // high carries one result word that must match the oldest prediction.
  always @(posedge clk) begin : result_check
    label_word_t want;
    if (rst_n && out_valid) begin
      if (pending_labels.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result word: expected none, actual label %0h count %0h",
                 $time, out_label, out_pixel_count);
      end else begin
        want = pending_labels.pop_front();
        check_field("label", want.label, out_label);
        check_field("blue", want.blue, out_blue);
        check_field("green", want.green, out_green);
        check_field("red", want.red, out_red);
        check_field("pixel count", want.count, out_pixel_count);
      end
    end
  end

  // Watchdog: any accepted command word, result word or register access
  // counts as progress. A long run of cycles without any of them is a hang.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    stim_row_t rows[$];
    pixel_cmd_t c;
    int idle_pct [4];
    int p;
    int k;
    int e;
    logic [31:0] nc;
    logic [31:0] polar;
    logic [31:0] mask_en;
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] scale;

    // Phases cycle through no gaps, heavy gaps, no gaps, light gaps.
    idle_pct[0] = 0;
    idle_pct[1] = 75;
    idle_pct[2] = 0;
    idle_pct[3] = 23;

    // Shadow state after reset.
    for (e = 0; e < ENTRIES; e++) begin
      centroid_means[e] = '0;
      pixel_counts[e] = '0;
    end
    cfg_clusters = NUM_CLUSTERS_RST;
    cfg_polar = 1'b0;
    cfg_mask = 1'b0;
    cfg_width = IMAGE_WIDTH_RST;
    cfg_height = IMAGE_HEIGHT_RST;
    cfg_scale = RADIUS_SCALE_RST;

    // Directed list. Means are written {radius, red, green, blue}. Every
    // classify here only scans entries that were loaded before it.
    // Counts read straight after reset are zero.
    rows.push_back(with_word(cmd_row(REQ_COUNT, 0, 0, 0, 0, 0, 0, 0, '0), 0, 0, 0, 0, 0));
    rows.push_back(with_word(cmd_row(REQ_COUNT, 31, 0, 0, 0, 0, 0, 0, '0), 31, 0, 0, 0, 0));
    rows.push_back(cmd_row(REQ_LOAD, 0, 0, 0, 0, 0, 0, 0,
                           {16'h4000, 16'h0080, 16'hFF00, 16'h12AB}));
    // One entry in use: whatever the pixel, entry 0 wins.
    rows.push_back(with_word(cmd_row(REQ_CLASSIFY, 0, 0, 0, 0, 0, 0, 0, '0),
                             0, 8'h12, 8'hFF, 8'h00, 1));
    rows.push_back(cmd_row(REQ_CLASSIFY, 31, 8'hFF, 8'hFF, 8'hFF, 12'hFFF, 12'hFFF, 1,
                           {4{16'hFFFF}}));
    rows.push_back(with_word(cmd_row(REQ_COUNT, 0, 0, 0, 0, 0, 0, 0, '0), 0, 0, 0, 0, 2));
    rows.push_back(cmd_row(REQ_LOAD, 31, 8'hFF, 8'hFF, 8'hFF, 12'hFFF, 12'hFFF, 1,
                           {4{16'hFFFF}}));
    rows.push_back(cmd_row(REQ_LOAD, 1, 0, 0, 0, 0, 0, 0, '0));
    rows.push_back(cmd_row(REQ_LOAD, 2, 0, 0, 0, 0, 0, 0, '0));
    // Reserved request code with every field at its maximum: no result.
    rows.push_back(cmd_row(REQ_RESERVED, 31, 8'hFF, 8'hFF, 8'hFF, 12'hFFF, 12'hFFF, 1,
                           {4{16'hFFFF}}));
    // Zero entries in use behaves as one.
    rows.push_back(reg_row(REG_NUM_CLUSTERS, 0));
    rows.push_back(cmd_row(REQ_CLASSIFY, 0, 200, 10, 77, 5, 9, 1, '0));
    // Entries 1 and 2 are identical, so a black pixel ties and picks entry 1.
    rows.push_back(reg_row(REG_NUM_CLUSTERS, 3));
    rows.push_back(cmd_row(REQ_CLASSIFY, 0, 0, 0, 0, 0, 0, 1, '0));
    // Reloading an entry clears its count.
    rows.push_back(cmd_row(REQ_LOAD, 0, 0, 0, 0, 0, 0, 0,
                           {16'h0100, 16'h8000, 16'h8000, 16'h8000}));
    rows.push_back(with_word(cmd_row(REQ_COUNT, 0, 0, 0, 0, 0, 0, 0, '0), 0, 0, 0, 0, 0));
    // Masked pixel: fixed label, zero colour, no count change.
    rows.push_back(reg_row(REG_MASK_ENABLE, 1));
    rows.push_back(with_word(cmd_row(REQ_CLASSIFY, 0, 8'hFF, 8'hFF, 8'hFF, 0, 0, 0, '0),
                             LABEL_MASKED, 0, 0, 0, 0));
    rows.push_back(cmd_row(REQ_CLASSIFY, 0, 128, 128, 128, 0, 0, 1, '0));
    // Polar mode at both coordinate extremes, then with the scale at its maximum so
    // that the radius feature saturates, on a degenerate image shape.
    rows.push_back(reg_row(REG_POLAR_MODE, 1));
    rows.push_back(cmd_row(REQ_CLASSIFY, 0, 0, 0, 0, 0, 0, 1, '0));
    rows.push_back(cmd_row(REQ_CLASSIFY, 0, 1, 2, 3, 12'hFFF, 12'hFFF, 1, '0));
    rows.push_back(reg_row(REG_RADIUS_SCALE, 24'hFFFFFF));
    rows.push_back(reg_row(REG_IMAGE_WIDTH, 1));
    rows.push_back(reg_row(REG_IMAGE_HEIGHT, 4096));
    rows.push_back(cmd_row(REQ_CLASSIFY, 0, 128, 128, 128, 2048, 0, 1, '0));
    rows.push_back(cmd_row(REQ_CLASSIFY, 0, 0, 255, 0, 12'hFFF, 12'hFFF, 1, '0));
    rows.push_back(cmd_row(REQ_COUNT, 1, 0, 0, 0, 0, 0, 0, '0));
    rows.push_back(cmd_row(REQ_COUNT, 2, 0, 0, 0, 0, 0, 0, '0));

    // Synchronous reset, held at the start of the run.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].is_reg) begin
        drain_and_settle();
        write_reg(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        send_item(rows[i].cmd, rows[i].typed, rows[i].want);
      end
    end

    // Fill every entry before any phase may scan the whole table.
    for (e = 0; e < ENTRIES; e++) begin
      c = '0;
      c.req = REQ_LOAD;
      c.idx = e;
      c.means = {$urandom, $urandom};
      send_item(c, 1'b0, '0);
    end

    for (p = 0; p < PHASES; p++) begin
      drain_and_settle();
      // The first phases pin the register extremes; the rest are random.
      case (p)
        0: begin
          nc = 32; polar = 1; mask_en = 0; w = 4096; h = 1; scale = 24'hFFFFFF;
        end
        1: begin
          nc = 63; polar = 0; mask_en = 1; w = 640; h = 480; scale = 65536;
        end
        2: begin
          nc = 1; polar = 1; mask_en = 1; w = 1; h = 4096; scale = 0;
        end
        3: begin
          nc = 33; polar = 1; mask_en = 0; w = 1; h = 1; scale = 65536;
        end
        default: begin
          nc = $urandom_range(63);
          polar = $urandom_range(1);
          mask_en = $urandom_range(1);
          w = $urandom_range(4096, 1);
          h = $urandom_range(4096, 1);
          scale = $urandom_range(24'hFFFFFF);
        end
      endcase
      write_reg(REG_NUM_CLUSTERS, nc);
      write_reg(REG_POLAR_MODE, polar);
      write_reg(REG_MASK_ENABLE, mask_en);
      write_reg(REG_IMAGE_WIDTH, w);
      write_reg(REG_IMAGE_HEIGHT, h);
      write_reg(REG_RADIUS_SCALE, scale);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        idle_gap(idle_pct[p % 4]);
        send_item(random_command(), 1'b0, '0);
      end
    end

    drain_and_settle();
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
